// ===== hw/rtl/bbms_pkg.sv =====
// Shared types and constants for the buzzer beep and melody sequencer.
// Item kinds, register indexes, reset values and the packed item, note,
// result and configuration structs. No dependencies.
`timescale 1ns / 1ps

package bbms_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_BEEP   = 2'd1;
    localparam logic [1:0] KIND_MELODY = 2'd2;
    localparam logic [1:0] KIND_LOAD   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLANK_TIME    = 2'd0;
    localparam logic [1:0] CFG_TICK_DIVIDE   = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_PITCH = 2'd2;

    // Register reset values
    localparam logic [7:0]  RST_BLANK_TIME    = 8'd150;
    localparam logic [7:0]  RST_TICK_DIVIDE   = 8'd10;
    localparam logic [15:0] RST_DEFAULT_PITCH = 16'd2000;

    // Slot fields are 6 bits wide on the bus
    localparam int SLOT_W     = 6;
    localparam int SLOT_COUNT = 1 << SLOT_W;

    typedef struct packed {
        logic [15:0] pitch;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } note_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        beep_count;
        logic [7:0]        beep_on_time;
        logic [7:0]        beep_gap;
        logic [SLOT_W-1:0] melody_start;
        logic [6:0]        melody_length;
        logic [SLOT_W-1:0] note_slot;
        note_t             note;
    } item_t;

    typedef struct packed {
        logic [15:0] pitch;
        logic        melody_active;
        logic        envelope_power;
        logic        beep_on;
        logic        accepted;
    } result_t;

    typedef struct packed {
        logic [7:0]  blank_time;
        logic [7:0]  tick_divide;
        logic [15:0] default_pitch;
    } cfg_t;

endpackage

// ===== hw/rtl/bbms_note_mem.sv =====
// Note store: one write port and one registered read port.
// Depends on bbms_pkg for the note entry type.
`timescale 1ns / 1ps

module bbms_note_mem #(
    parameter int NOTE_DEPTH = 64,
    parameter int AW         = $clog2(NOTE_DEPTH)
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  bbms_pkg::note_t        wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output bbms_pkg::note_t        rdata
);

    bbms_pkg::note_t mem [NOTE_DEPTH];
    bbms_pkg::note_t rdata_reg;

    // Write and registered read; entries have no reset
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bbms_seq_core.sv =====
// Sequencer state and its single-pass update: blanking, tick divider,
// beep engine, melody engine, plus the note store address generation.
// Depends on bbms_pkg.
`timescale 1ns / 1ps

module bbms_seq_core #(
    parameter int NOTE_DEPTH = 64,
    parameter int AW         = $clog2(NOTE_DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bbms_pkg::cfg_t          cfg,
    // item being processed
    input  logic                    fire,
    input  bbms_pkg::item_t         item,
    input  bbms_pkg::note_t         rd_note,
    // item being accepted this cycle
    input  logic                    s_accept,
    input  bbms_pkg::item_t         s_item,
    // note store access
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output bbms_pkg::note_t         mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr,
    // result of the item being processed
    output bbms_pkg::result_t       result
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(NOTE_DEPTH - 1);

    // Bus slot number folded into the store depth
    logic [AW-1:0] slot_wrap [bbms_pkg::SLOT_COUNT];

    for (genvar g = 0; g < bbms_pkg::SLOT_COUNT; g++)
    begin : g_slot_wrap
        assign slot_wrap[g] = AW'(g % NOTE_DEPTH);
    end

    logic [7:0]    blank_left_reg,    blank_left_next;
    logic          blank_flag_reg,    blank_flag_next;
    logic [7:0]    divider_count_reg, divider_count_next;
    logic [7:0]    bursts_left_reg,   bursts_left_next;
    logic [7:0]    burst_timer_reg,   burst_timer_next;
    logic [7:0]    gap_timer_reg,     gap_timer_next;
    logic [7:0]    burst_reload_reg,  burst_reload_next;
    logic [7:0]    gap_reload_reg,    gap_reload_next;
    logic [6:0]    notes_left_reg,    notes_left_next;
    logic [15:0]   sound_left_reg,    sound_left_next;
    logic [15:0]   silence_left_reg,  silence_left_next;
    logic [15:0]   pitch_reg,         pitch_next;
    logic          active_reg,        active_next;
    logic          power_reg,         power_next;
    logic [AW-1:0] cur_slot_reg,      cur_slot_next;

    logic [7:0]    div_inc;
    logic [AW-1:0] slot_inc;
    logic [AW-1:0] slot_after;
    logic          accepted;

    assign div_inc    = divider_count_reg + 8'd1;
    assign slot_inc   = (cur_slot_reg == LAST_SLOT) ? '0 : cur_slot_reg + AW'(1);
    assign slot_after = (cur_slot_next == LAST_SLOT) ? '0 : cur_slot_next + AW'(1);

    // Next state for the item being processed
    always_comb
    begin
        blank_left_next    = blank_left_reg;
        blank_flag_next    = blank_flag_reg;
        divider_count_next = divider_count_reg;
        bursts_left_next   = bursts_left_reg;
        burst_timer_next   = burst_timer_reg;
        gap_timer_next     = gap_timer_reg;
        burst_reload_next  = burst_reload_reg;
        gap_reload_next    = gap_reload_reg;
        notes_left_next    = notes_left_reg;
        sound_left_next    = sound_left_reg;
        silence_left_next  = silence_left_reg;
        pitch_next         = pitch_reg;
        active_next        = active_reg;
        power_next         = power_reg;
        cur_slot_next      = cur_slot_reg;
        accepted           = 1'b0;

        if (fire)
        begin
            unique case (item.kind)
                bbms_pkg::KIND_TICK:
                begin
                    // select blanking countdown
                    if (blank_left_reg != 8'd0)
                    begin
                        blank_left_next = blank_left_reg - 8'd1;
                    end
                    else
                    begin
                        blank_flag_next = 1'b0;
                    end

                    // tick divider and beep engine step
                    if (div_inc >= cfg.tick_divide)
                    begin
                        divider_count_next = 8'd0;
                        if (bursts_left_reg != 8'd0)
                        begin
                            if (burst_timer_reg != 8'd0)
                            begin
                                burst_timer_next = burst_timer_reg - 8'd1;
                            end
                            else if (gap_timer_reg != 8'd0)
                            begin
                                gap_timer_next = gap_timer_reg - 8'd1;
                            end
                            else
                            begin
                                bursts_left_next = bursts_left_reg - 8'd1;
                                if (bursts_left_reg != 8'd1)
                                begin
                                    burst_timer_next = burst_reload_reg;
                                    gap_timer_next   = gap_reload_reg;
                                end
                            end
                        end
                    end
                    else
                    begin
                        divider_count_next = div_inc;
                    end

                    // melody engine step
                    if (sound_left_reg != 16'd0)
                    begin
                        sound_left_next = sound_left_reg - 16'd1;
                        power_next      = 1'b1;
                    end
                    else if (silence_left_reg != 16'd0)
                    begin
                        silence_left_next = silence_left_reg - 16'd1;
                        power_next        = 1'b0;
                    end
                    else
                    begin
                        active_next = (notes_left_reg != 7'd0);
                        if (notes_left_reg != 7'd0)
                        begin
                            notes_left_next = notes_left_reg - 7'd1;
                            // more notes left: the prefetched entry is the next note
                            if (notes_left_reg != 7'd1)
                            begin
                                pitch_next        = rd_note.pitch;
                                sound_left_next   = rd_note.on_ms;
                                silence_left_next = rd_note.off_ms;
                                active_next       = 1'b1;
                                power_next        = 1'b1;
                                cur_slot_next     = slot_inc;
                            end
                        end
                    end
                end

                bbms_pkg::KIND_BEEP,
                bbms_pkg::KIND_MELODY:
                begin
                    // every select reopens the blanking window
                    blank_left_next = cfg.blank_time;
                    if (!blank_flag_reg)
                    begin
                        blank_flag_next  = 1'b1;
                        accepted         = 1'b1;
                        bursts_left_next = 8'd0;
                        burst_timer_next = 8'd0;
                        gap_timer_next   = 8'd0;
                        if ((item.kind == bbms_pkg::KIND_BEEP) ||
                            (item.melody_length == 7'd0))
                        begin
                            // melody stop; envelope power keeps its value
                            notes_left_next   = 7'd0;
                            sound_left_next   = 16'd0;
                            silence_left_next = 16'd0;
                            active_next       = 1'b0;
                            pitch_next        = cfg.default_pitch;
                        end
                        if ((item.kind == bbms_pkg::KIND_BEEP) &&
                            (item.beep_count != 8'd0))
                        begin
                            bursts_left_next  = item.beep_count;
                            burst_reload_next = item.beep_on_time;
                            gap_reload_next   = item.beep_gap;
                            burst_timer_next  = item.beep_on_time;
                            gap_timer_next    = item.beep_gap;
                        end
                        if ((item.kind == bbms_pkg::KIND_MELODY) &&
                            (item.melody_length != 7'd0))
                        begin
                            // first note was read at the melody start slot
                            notes_left_next   = item.melody_length;
                            pitch_next        = rd_note.pitch;
                            sound_left_next   = rd_note.on_ms;
                            silence_left_next = rd_note.off_ms;
                            active_next       = 1'b1;
                            power_next        = 1'b1;
                            cur_slot_next     = slot_wrap[item.melody_start];
                        end
                    end
                end

                bbms_pkg::KIND_LOAD:
                begin
                    // store written on acceptance; no state change here
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_left_reg    <= 8'd0;
            blank_flag_reg    <= 1'b0;
            divider_count_reg <= 8'd0;
            bursts_left_reg   <= 8'd0;
            burst_timer_reg   <= 8'd0;
            gap_timer_reg     <= 8'd0;
            burst_reload_reg  <= 8'd0;
            gap_reload_reg    <= 8'd0;
            notes_left_reg    <= 7'd0;
            sound_left_reg    <= 16'd0;
            silence_left_reg  <= 16'd0;
            pitch_reg         <= bbms_pkg::RST_DEFAULT_PITCH;
            active_reg        <= 1'b0;
            power_reg         <= 1'b0;
            cur_slot_reg      <= '0;
        end
        else
        begin
            blank_left_reg    <= blank_left_next;
            blank_flag_reg    <= blank_flag_next;
            divider_count_reg <= divider_count_next;
            bursts_left_reg   <= bursts_left_next;
            burst_timer_reg   <= burst_timer_next;
            gap_timer_reg     <= gap_timer_next;
            burst_reload_reg  <= burst_reload_next;
            gap_reload_reg    <= gap_reload_next;
            notes_left_reg    <= notes_left_next;
            sound_left_reg    <= sound_left_next;
            silence_left_reg  <= silence_left_next;
            pitch_reg         <= pitch_next;
            active_reg        <= active_next;
            power_reg         <= power_next;
            cur_slot_reg      <= cur_slot_next;
        end
    end

    // Note store access for the incoming item, based on state after this edge
    assign mem_we    = s_accept && (s_item.kind == bbms_pkg::KIND_LOAD);
    assign mem_waddr = slot_wrap[s_item.note_slot];
    assign mem_wdata = s_item.note;
    assign mem_re    = s_accept && (s_item.kind != bbms_pkg::KIND_LOAD);
    assign mem_raddr = (s_item.kind == bbms_pkg::KIND_MELODY) ?
                       slot_wrap[s_item.melody_start] : slot_after;

    // Result of the item being processed
    assign result.pitch          = pitch_next;
    assign result.melody_active  = active_next;
    assign result.envelope_power = power_next;
    assign result.beep_on        = (burst_timer_next != 8'd0);
    assign result.accepted       = accepted;

endmodule

// ===== hw/rtl/buzzer_beep_and_melody_sequencer.sv =====
// Buzzer beep and melody sequencer: top level with stream ports, input and
// result registers, configuration registers and the note store.
// Depends on bbms_pkg, bbms_note_mem and bbms_seq_core.
//
// Usage:
//   s_* carries one item per transaction: s_tuser holds the kind (tick,
//   beep select, melody select, note load), s_tdata the select and load
//   fields. Every accepted item produces exactly one result transaction
//   on m_*, in order: current pitch and the melody, envelope, beep and
//   select-accepted flags.
//   cfg_* writes blank_time, tick_divide and default_pitch by index; it is
//   always ready and is meant to be used while the block is idle.
//   The accepting edge loads the input register and reads the note store;
//   the result register is loaded when the item is processed, once it is
//   free or draining. Throughput is one item per cycle while m_tready is
//   high, set by the state update loop and the one read port of the store.
//   Reset clears all sequencer state, restores the register defaults and
//   sets the pitch to 2000; the note store keeps no reset contents.
//   When m_tready is low the result register holds its transaction, one
//   more item waits in the input register, and then s_tready drops.
`timescale 1ns / 1ps

module buzzer_beep_and_melody_sequencer #(
    parameter int NOTE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] beep_count, [15:8] beep_on_time, [23:16] beep_gap,
    // [29:24] melody_start, [36:30] melody_length, [42:37] note_slot,
    // [58:43] note_pitch, [74:59] note_on_ms, [90:75] note_off_ms, [95:91] zero
    input  logic [95:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] pitch, [16] melody_active, [17] envelope_power, [18] beep_on,
    // [19] accepted, [23:20] zero
    output logic [23:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(NOTE_DEPTH);

    bbms_pkg::item_t   s_item;
    bbms_pkg::item_t   item_reg;
    logic              in_valid_reg;
    bbms_pkg::result_t result;
    bbms_pkg::result_t out_reg;
    logic              out_valid_reg;
    bbms_pkg::cfg_t    cfg_reg;
    bbms_pkg::note_t   rd_note;

    logic              s_accept;
    logic              fire;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    bbms_pkg::note_t   mem_wdata;

    // Unpack the incoming transaction
    always_comb
    begin
        s_item.kind          = s_tuser;
        s_item.beep_count    = s_tdata[7:0];
        s_item.beep_on_time  = s_tdata[15:8];
        s_item.beep_gap      = s_tdata[23:16];
        s_item.melody_start  = s_tdata[29:24];
        s_item.melody_length = s_tdata[36:30];
        s_item.note_slot     = s_tdata[42:37];
        s_item.note.pitch    = s_tdata[58:43];
        s_item.note.on_ms    = s_tdata[74:59];
        s_item.note.off_ms   = s_tdata[90:75];
    end

    // Handshake: process when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg <= s_item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.accepted, out_reg.beep_on,
                       out_reg.envelope_power, out_reg.melody_active, out_reg.pitch};

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blank_time    <= bbms_pkg::RST_BLANK_TIME;
            cfg_reg.tick_divide   <= bbms_pkg::RST_TICK_DIVIDE;
            cfg_reg.default_pitch <= bbms_pkg::RST_DEFAULT_PITCH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bbms_pkg::CFG_BLANK_TIME:    cfg_reg.blank_time    <= cfg_data[7:0];
                bbms_pkg::CFG_TICK_DIVIDE:   cfg_reg.tick_divide   <= cfg_data[7:0];
                bbms_pkg::CFG_DEFAULT_PITCH: cfg_reg.default_pitch <= cfg_data;
                default:
                begin
                    // index beyond the register list: ignored
                end
            endcase
        end
    end

    // Note store
    bbms_note_mem #(
        .NOTE_DEPTH (NOTE_DEPTH),
        .AW         (AW)
    ) u_note_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_note)
    );

    // Sequencer state and update
    bbms_seq_core #(
        .NOTE_DEPTH (NOTE_DEPTH),
        .AW         (AW)
    ) u_seq_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .item      (item_reg),
        .rd_note   (rd_note),
        .s_accept  (s_accept),
        .s_item    (s_item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .result    (result)
    );

endmodule
